>>> hdl/rde_pkg.sv
package rde_pkg;

  localparam logic [1:0] RADIX_HEX_LOWER = 2'd1;
  localparam logic [1:0] RADIX_HEX_UPPER = 2'd2;

  localparam logic [6:0] ASCII_ZERO    = 7'h30;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [3:0] DIGIT_TEN     = 4'd10;

  typedef struct packed {
    logic load;
    logic step;
    logic dec_idx;
    logic emit;
  } rde_cmd_t;

  typedef struct packed {
    logic hex_in;
    logic bits_done;
    logic idx_zero;
    logic dig_zero;
  } rde_sts_t;

endpackage

>>> hdl/radix_digit_emitter.sv
// radix_digit_emitter
// Converts an unsigned number into ASCII digit characters, most significant
// first, without leading zeros; zero gives a single '0'. in_radix_mode picks
// decimal (0, and also 3), lower-case hex (1) or upper-case hex (2).
// Input channel: in_valid/in_ready with in_value and in_radix_mode.
// Output channel: out_valid/out_ready with one item per digit; out_last_digit
// marks the least significant digit of each number.
// Steps per number: load, then shift-and-add-3 binary-to-BCD conversion of
// one input bit per step (decimal only), then a skip over leading zero
// positions (up to MAX_DIGITS-1), then one output item per digit emitted.
// Conversion time is set by the serial BCD shift and the single
// digit-select read port.
// A new number is taken as soon as the previous one's last digit has been
// loaded into the output register, even while that digit is still waiting.
// If the receiver stalls, emission pauses with the current item held.
// Numbers needing more than MAX_DIGITS digits keep only the low digits.
// Reset (rst_n low, synchronous) empties the output and returns to idle.
module radix_digit_emitter
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic [1:0]             in_radix_mode,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [6:0]             out_ascii_char,
  output logic                   out_last_digit
);

  rde_cmd_t cmd;
  rde_sts_t sts;

  rde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rde_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_radix_mode  (in_radix_mode),
    .cmd            (cmd),
    .sts            (sts),
    .out_ascii_char (out_ascii_char),
    .out_last_digit (out_last_digit)
  );

endmodule

>>> hdl/rde_datapath.sv
module rde_datapath
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic [1:0]             in_radix_mode,
  input  rde_cmd_t               cmd,
  output rde_sts_t               sts,
  output logic [6:0]             out_ascii_char,
  output logic                   out_last_digit
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [3:0]             dig_r   [MAX_DIGITS];
  logic [3:0]             dig_nxt [MAX_DIGITS];
  logic [3:0]             hex_dig [MAX_DIGITS];
  logic [3:0]             adj     [MAX_DIGITS];
  logic [CNT_W-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   upper_r, upper_nxt;
  logic [6:0]             char_r, char_nxt;
  logic                   last_r, last_nxt;
  logic [3:0]             cur_dig;

  // nibble view of the input, zero above the value width
  for (genvar gi = 0; gi < MAX_DIGITS; gi++) begin : g_nib
    for (genvar gj = 0; gj < 4; gj++) begin : g_bit
      if (4 * gi + gj < VALUE_WIDTH) begin : g_in
        assign hex_dig[gi][gj] = in_value[4*gi+gj];
      end else begin : g_pad
        assign hex_dig[gi][gj] = 1'b0;
      end
    end
  end

  // shift-and-add-3 correction per BCD digit
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
  end

  assign cur_dig = dig_r[idx_r];

  assign sts.hex_in    = (in_radix_mode == RADIX_HEX_LOWER) ||
                         (in_radix_mode == RADIX_HEX_UPPER);
  assign sts.bits_done = (bit_cnt_r == CNT_W'(VALUE_WIDTH - 1));
  assign sts.idx_zero  = (idx_r == '0);
  assign sts.dig_zero  = (cur_dig == 4'd0);

  always_comb begin
    dig_nxt     = dig_r;
    val_nxt     = val_r;
    bit_cnt_nxt = bit_cnt_r;
    idx_nxt     = idx_r;
    upper_nxt   = upper_r;
    char_nxt    = char_r;
    last_nxt    = last_r;
    if (cmd.load) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        dig_nxt[i] = sts.hex_in ? hex_dig[i] : 4'd0;
      end
      val_nxt     = in_value;
      bit_cnt_nxt = '0;
      idx_nxt     = IDX_W'(MAX_DIGITS - 1);
      upper_nxt   = (in_radix_mode == RADIX_HEX_UPPER);
    end else if (cmd.step) begin
      dig_nxt[0] = {adj[0][2:0], val_r[VALUE_WIDTH-1]};
      for (int i = 1; i < MAX_DIGITS; i++) begin
        dig_nxt[i] = {adj[i][2:0], adj[i-1][3]};
      end
      val_nxt     = {val_r[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end
    if (cmd.dec_idx) begin
      idx_nxt = idx_r - 1'b1;
    end
    if (cmd.emit) begin
      if (cur_dig < DIGIT_TEN) begin
        char_nxt = ASCII_ZERO + {3'b000, cur_dig};
      end else begin
        char_nxt = (upper_r ? ASCII_UPPER_A : ASCII_LOWER_A) + {3'b000, cur_dig} -
                   {3'b000, DIGIT_TEN};
      end
      last_nxt = sts.idx_zero;
    end
  end

  always_ff @(posedge clk) begin
    dig_r     <= dig_nxt;
    val_r     <= val_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    idx_r     <= idx_nxt;
    upper_r   <= upper_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

  assign out_ascii_char = char_r;
  assign out_last_digit = last_r;

  a_no_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec_idx |-> !sts.idx_zero)
    else $error("digit index decremented below zero");

endmodule

>>> hdl/rde_ctrl.sv
module rde_ctrl
  import rde_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rde_sts_t sts,
  output rde_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  assign cmd.load    = (state_r == S_IDLE) && in_valid;
  assign cmd.step    = (state_r == S_CONV);
  assign cmd.emit    = (state_r == S_EMIT) && out_free;
  assign cmd.dec_idx = ((state_r == S_SKIP) && sts.dig_zero && !sts.idx_zero) ||
                       (cmd.emit && !sts.idx_zero);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.hex_in ? S_SKIP : S_CONV;
        end
      end
      S_CONV: begin
        if (sts.bits_done) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (!sts.dig_zero || sts.idx_zero) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd.emit) begin
          out_valid_nxt = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_ready))
    else $error("stalled output item overwritten");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.idx_zero) |=> (state_r == S_IDLE) && out_valid_r)
    else $error("last digit did not end the number");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rde_pkg::*;

  localparam int VW       = 64;
  localparam int MAXD     = 20;
  localparam int N_RANDOM = 330;
  localparam int SETTLE   = 120;
  localparam int LIMIT    = 400000;

  localparam logic [1:0] RADIX_DEC     = 2'd0;
  localparam logic [1:0] RADIX_DEC_ALT = 2'd3;

  typedef struct {
    logic [VW-1:0] value;
    logic [1:0]    mode;
    bit            drain;
  } num_item_t;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } digit_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [VW-1:0] in_value = '0;
  logic [1:0]    in_radix_mode = RADIX_DEC;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [6:0]    out_ascii_char;
  logic          out_last_digit;

  num_item_t numbers_pending[$];
  digit_t    digits_due[$];
  digit_t    digit_exp;
  int        total_items = 0;
  int        items_taken = 0;
  int        digits_seen = 0;
  int        failures = 0;
  int        cycles = 0;
  int        mode_seen[4] = '{0, 0, 0, 0};

  radix_digit_emitter #(
    .VALUE_WIDTH(VW),
    .MAX_DIGITS (MAXD)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_radix_mode (in_radix_mode),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ascii_char(out_ascii_char),
    .out_last_digit(out_last_digit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d digits outstanding", cycles,
               digits_due.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // idle phases: sender light / receiver heavy, then swapped, then none
  function automatic int phase_now();
    if (total_items == 0) return 2;
    return (items_taken * 3) / total_items;
  endfunction

  function automatic int send_idle_pct();
    case (phase_now())
      0: return 17;
      1: return 85;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (phase_now())
      0: return 85;
      1: return 17;
      default: return 0;
    endcase
  endfunction

  // digits kept least significant first, emitted most significant first
  task automatic queue_digits(input logic [VW-1:0] value, input logic [1:0] mode);
    logic [VW-1:0] rest;
    logic [VW-1:0] base;
    logic [3:0]    kept[MAXD];
    logic [3:0]    d;
    int            cnt;
    digit_t        e;
    rest = value;
    base = (mode == RADIX_HEX_LOWER || mode == RADIX_HEX_UPPER) ? 64'd16 : 64'd10;
    cnt  = 0;
    do begin
      d = 4'(rest % base);
      if (cnt < MAXD) begin
        kept[cnt] = d;
        cnt++;
      end
      rest = rest / base;
    end while (rest != 0);
    for (int k = cnt; k > 0; k--) begin
      d = kept[k-1];
      if (d < DIGIT_TEN) begin
        e.ch = ASCII_ZERO + 7'(d);
      end else if (mode == RADIX_HEX_UPPER) begin
        e.ch = ASCII_UPPER_A + 7'(d - DIGIT_TEN);
      end else begin
        e.ch = ASCII_LOWER_A + 7'(d - DIGIT_TEN);
      end
      e.last = (k == 1);
      digits_due.push_back(e);
    end
  endtask

  task automatic add_number(input logic [VW-1:0] value, input logic [1:0] mode,
                            input bit drain);
    num_item_t it;
    it.value = value;
    it.mode  = mode;
    it.drain = drain;
    numbers_pending.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        queue_digits(in_value, in_radix_mode);
        mode_seen[in_radix_mode]++;
        items_taken++;
      end
      if (numbers_pending.size() != 0 &&
          !(numbers_pending[0].drain && digits_due.size() != 0) &&
          $urandom_range(99) >= send_idle_pct()) begin
        in_value      <= numbers_pending[0].value;
        in_radix_mode <= numbers_pending[0].mode;
        in_valid      <= 1'b1;
        void'(numbers_pending.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (digits_due.size() == 0) begin
          $error("unexpected digit: ascii_char %0h last_digit %0b", out_ascii_char,
                 out_last_digit);
          failures++;
        end else begin
          digit_exp = digits_due.pop_front();
          digits_seen++;
          if (out_ascii_char !== digit_exp.ch) begin
            $error("ascii_char: expected %0h, got %0h", digit_exp.ch, out_ascii_char);
            failures++;
          end
          if (out_last_digit !== digit_exp.last) begin
            $error("last_digit: expected %0b, got %0b", digit_exp.last, out_last_digit);
            failures++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  initial begin
    logic [VW-1:0] v;
    logic [VW-1:0] p;
    logic [1:0]    m;
    int            sel;

    // directed
    add_number('0, RADIX_DEC, 1'b0);
    add_number('0, RADIX_HEX_LOWER, 1'b0);
    add_number('0, RADIX_HEX_UPPER, 1'b0);
    add_number('0, RADIX_DEC_ALT, 1'b0);
    add_number('1, RADIX_DEC, 1'b0);
    add_number('1, RADIX_HEX_LOWER, 1'b0);
    add_number('1, RADIX_HEX_UPPER, 1'b0);
    add_number('1, RADIX_DEC_ALT, 1'b0);
    add_number(64'd1, RADIX_DEC, 1'b0);
    add_number(64'd9, RADIX_DEC, 1'b0);
    add_number(64'd10, RADIX_DEC, 1'b0);
    add_number(64'd15, RADIX_HEX_LOWER, 1'b0);
    add_number(64'd16, RADIX_HEX_UPPER, 1'b0);
    add_number(64'hABCDEF, RADIX_HEX_LOWER, 1'b0);
    add_number(64'hABCDEF, RADIX_HEX_UPPER, 1'b0);
    add_number(64'd10000000000000000000, RADIX_DEC, 1'b0);
    add_number(64'd9999999999999999999, RADIX_DEC, 1'b0);
    add_number(64'h8000_0000_0000_0000, RADIX_DEC, 1'b0);
    add_number(64'h8000_0000_0000_0000, RADIX_HEX_LOWER, 1'b0);
    add_number(64'h0123_4567_89AB_CDEF, RADIX_HEX_UPPER, 1'b0);
    add_number(64'hFEDC_BA98_7654_3210, RADIX_HEX_LOWER, 1'b0);
    add_number(64'd1234567890, RADIX_DEC_ALT, 1'b1);

    // random, mixed magnitudes and digit-count boundaries
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(9);
      case (sel)
        0, 1, 2, 3: v = {$urandom, $urandom};
        4, 5: v = {$urandom, $urandom} >> $urandom_range(63);
        6: begin
          p = 64'd1;
          repeat ($urandom_range(19)) p = p * 64'd10;
          v = p + 64'($urandom_range(2)) - 64'd1;
        end
        7: v = (64'd1 << (4 * $urandom_range(15))) + 64'($urandom_range(2)) - 64'd1;
        8: v = 64'($urandom_range(255));
        default: v = $urandom_range(1) ? '1 : '0;
      endcase
      m = 2'($urandom_range(3));
      add_number(v, m, (i % 110 == 0) || ($urandom_range(49) == 0));
    end
    total_items = numbers_pending.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (numbers_pending.size() != 0 || in_valid) @(posedge clk);
    while (digits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("tb_top: %0d numbers converted (dec %0d, hex lower %0d, hex upper %0d, mode 3 %0d)",
             items_taken, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
    $display("tb_top: %0d digits checked under three stall profiles, %0d mismatches",
             digits_seen, failures);
    if (failures == 0 && digits_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
